// ----- sv/wic_pkg.sv -----
// shared constants and elaboration-time helpers for the weibull inverse cdf sampler
// no dependencies; used by wic_exp2_cell and weibull_inverse_cdf
package wic_pkg;

  localparam int unsigned FRAC_BITS_DEF = 32;
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [31:0] SHAPE_INV_RESET = 32'h0100_0000;
  localparam logic [63:0] LN2_Q32 = 64'h0000_0000_B172_17F8;

  // register indexes of the configuration channel
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_SHAPE_INV = 1'b1;

  // log2 of a constant, 32 fraction bits, evaluated at elaboration only
  function automatic logic [63:0] log2_const(input logic [63:0] v);
    logic [5:0] e;
    logic [63:0] z;
    logic [31:0] frac;
    e = '0;
    frac = '0;
    for (int j = 0; j < 64; j++) begin
      if (v[j]) e = 6'(j);
    end
    z = (v << (6'd63 - e)) >> 32;
    for (int i = 0; i < 32; i++) begin
      z = z * z;
      frac = {frac[30:0], z[63]};
      z = z[63] ? (z >> 32) : (z >> 31);
    end
    return {26'd0, e, frac};
  endfunction

  // truncated integer square root, elaboration only
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor 2^(2^-idx) in Q1.31 as the repeated square roots give it
  function automatic logic [31:0] exp2_factor(input int idx);
    logic [63:0] s;
    s = isqrt_const(64'd1 << 63);
    for (int j = 1; j < idx; j++) begin
      s = isqrt_const(s << 31);
    end
    return s[31:0];
  endfunction

  localparam logic [63:0] LOG2_LN2 = log2_const(LN2_Q32);

endpackage

// ----- sv/wic_log2_cell.sv -----
// one squaring step of the log2 chain: yields one fraction bit per cell
// depends on nothing; instantiated by wic_log2
module wic_log2_cell #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [31:0]   in_z,
  input  logic [31:0]   in_frac,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_z,
  output logic [31:0]   out_frac,
  output logic [SW-1:0] out_side
);

  logic [63:0] sq;

  // square the q1.31 mantissa; a product of 2.0 or more gives a one bit
  assign sq = 64'(in_z) * 64'(in_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_z    <= sq[63] ? sq[63:32] : sq[62:31];
      out_frac <= {in_frac[30:0], sq[63]};
      out_side <= in_side;
    end
  end

endmodule

// ----- sv/wic_log2.sv -----
// log2 unit: top-bit encode, normalize, then a row of 32 squaring cells
// depends on wic_log2_cell
module wic_log2 #(
  parameter int VW = 32,
  parameter int SW = 1,
  localparam int NW = (VW < 32) ? 32 : VW,
  localparam int EW = $clog2(NW)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [VW-1:0]  in_v,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [EW+31:0] out_lg,
  output logic [SW-1:0]  out_side
);

  localparam int CW = SW + EW;

  logic          enc_valid;
  logic [NW-1:0] enc_v;
  logic [EW-1:0] enc_e;
  logic [SW-1:0] enc_side;
  logic [EW-1:0] top_bit;
  logic [NW-1:0] nv;
  logic [NW-1:0] shifted;

  logic          c_valid [0:32];
  logic [31:0]   c_z     [0:32];
  logic [31:0]   c_frac  [0:32];
  logic [CW-1:0] c_side  [0:32];

  // index of the top set bit
  assign nv = NW'(in_v);
  always_comb begin
    top_bit = '0;
    for (int j = 0; j < NW; j++) begin
      if (nv[j]) top_bit = EW'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid  <= 1'b0;
      c_valid[0] <= 1'b0;
    end else if (en) begin
      enc_valid  <= in_valid;
      c_valid[0] <= enc_valid;
    end
  end

  // normalize the mantissa to q1.31
  assign shifted = enc_v << (EW'(NW - 1) - enc_e);

  always_ff @(posedge clk) begin
    if (en) begin
      enc_v     <= nv;
      enc_e     <= top_bit;
      enc_side  <= in_side;
      c_z[0]    <= shifted[NW-1 -: 32];
      c_frac[0] <= '0;
      c_side[0] <= {enc_e, enc_side};
    end
  end

  // squaring cells
  for (genvar i = 0; i < 32; i++) begin : g_cell
    wic_log2_cell #(.SW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (c_valid[i]),
      .in_z     (c_z[i]),
      .in_frac  (c_frac[i]),
      .in_side  (c_side[i]),
      .out_valid(c_valid[i+1]),
      .out_z    (c_z[i+1]),
      .out_frac (c_frac[i+1]),
      .out_side (c_side[i+1])
    );
  end

  assign out_valid = c_valid[32];
  assign out_lg    = {c_side[32][CW-1:SW], c_frac[32]};
  assign out_side  = c_side[32][SW-1:0];

endmodule

// ----- sv/wic_exp2_cell.sv -----
// one step of the 2^frac chain: multiplies by 2^(2^-IDX) when its exponent bit is set
// depends on wic_pkg
module wic_exp2_cell #(
  parameter int IDX = 1,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [31:0]   in_r,
  input  logic [31:0]   in_f,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_r,
  output logic [31:0]   out_f,
  output logic [SW-1:0] out_side
);

  localparam logic [31:0] FACTOR = wic_pkg::exp2_factor(IDX);

  logic [63:0] prod;

  assign prod = 64'(in_r) * 64'(FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // truncated q1.31 product when the bit is set
  always_ff @(posedge clk) begin
    if (en) begin
      out_r    <= in_f[32-IDX] ? prod[62:31] : in_r;
      out_f    <= in_f;
      out_side <= in_side;
    end
  end

endmodule

// ----- sv/weibull_inverse_cdf.sv -----
// weibull inverse cdf sampler, top level: x = scale * 2^(shape_inverse * log2(-ln(1-y)))
// depends on wic_pkg, wic_log2, wic_exp2_cell
//
//   channel | direction | payload
//   s_*     | in        | tdata[31:0] quantile
//   m_*     | out       | tdata[31:0] sample_value, tuser[0] saturated
//   cfg_*   | in        | cfg_index register, cfg_data value
//
// one transaction is accepted per cycle unless a result waits on m_tready; the pipeline holds
// the two rows of 32 log2 squaring cells and the row of 32 exp2 multiply cells.
// reset clears all valid bits and loads scale 1.0 and shape_inverse 1.0.
// the whole pipeline holds while a result waits on m_tready.
module weibull_inverse_cdf #(
  parameter int QUANTILE_FRAC_BITS = wic_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] quantile
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sample_value
  output logic        m_tuser,   // [0] saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int MW = QUANTILE_FRAC_BITS + 1;
  localparam logic [63:0] FULL = 64'd1 << QUANTILE_FRAC_BITS;
  localparam logic [38:0] F_Q32 = 39'(QUANTILE_FRAC_BITS) << 32;
  localparam int EWA = $clog2((MW < 32) ? 32 : MW);
  localparam int EWB = $clog2(39);
  localparam logic [40:0] BIAS64 = 41'd64 << 32;
  localparam logic [47:0] LIM32 = 48'd32 << 32;
  localparam logic [47:0] LIM64 = 48'd64 << 32;
  localparam int XSW = 10;

  logic        en;
  logic [31:0] scale;
  logic [31:0] shape_inverse;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= wic_pkg::SCALE_RESET;
      shape_inverse <= wic_pkg::SHAPE_INV_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wic_pkg::REG_SCALE:     scale <= cfg_data;
        wic_pkg::REG_SHAPE_INV: shape_inverse <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: clamp quantile, form m = 2^F - q
  logic [63:0]   q_ext;
  logic [63:0]   q_cl;
  logic          in_valid;
  logic [MW-1:0] in_m;
  logic          in_zero;

  assign q_ext = 64'(s_tdata);
  assign q_cl  = (q_ext >= FULL) ? FULL - 64'd1 : q_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_m    <= MW'(FULL - q_cl);
      in_zero <= (q_cl == 64'd0) || (scale == 32'd0);
    end
  end

  // log2(m)
  logic           la_valid;
  logic [EWA+31:0] la_lg;
  logic           la_zero;

  wic_log2 #(.VW(MW), .SW(1)) u_log2_m (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_v     (in_m),
    .in_side  (in_zero),
    .out_valid(la_valid),
    .out_lg   (la_lg),
    .out_side (la_zero)
  );

  // L = F - log2(m)
  logic        l_valid;
  logic [38:0] l_val;
  logic        l_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (en) begin
      l_valid <= la_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_val  <= F_Q32 - 39'(la_lg);
      l_zero <= la_zero;
    end
  end

  // log2(L)
  logic           lb_valid;
  logic [EWB+31:0] lb_lg;
  logic           lb_zero;

  wic_log2 #(.VW(39), .SW(1)) u_log2_l (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (l_valid),
    .in_v     (l_val),
    .in_side  (l_zero),
    .out_valid(lb_valid),
    .out_lg   (lb_lg),
    .out_side (lb_zero)
  );

  // lg = log2(L) + log2(ln2) - 64, split into sign and magnitude
  logic [40:0] lg_pos;
  logic [40:0] lg;
  logic        g_valid;
  logic        g_neg;
  logic [38:0] g_mag;
  logic        g_zero;

  assign lg_pos = 41'(lb_lg) + 41'(wic_pkg::LOG2_LN2[37:0]);
  assign lg     = lg_pos - BIAS64;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= lb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_neg  <= lg[40];
      g_mag  <= lg[40] ? 39'(-lg) : lg[38:0];
      g_zero <= lb_zero;
    end
  end

  // multiply magnitude by shape_inverse
  logic        mu_valid;
  logic        mu_neg;
  logic [38:0] mu_hi;
  logic [63:0] mu_lo;
  logic        mu_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else if (en) begin
      mu_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_hi   <= 39'(g_mag[38:32]) * 39'(shape_inverse);
      mu_lo   <= 64'(g_mag[31:0]) * 64'(shape_inverse);
      mu_neg  <= g_neg;
      mu_zero <= g_zero;
    end
  end

  // exponent: range checks and biased split into integer and fraction
  logic [47:0]    e_mag;
  logic [47:0]    e_bias;
  logic           x_valid [0:32];
  logic [31:0]    x_r     [0:32];
  logic [31:0]    x_f     [0:32];
  logic [XSW-1:0] x_side  [0:32];

  assign e_mag  = (48'(mu_hi) << 8) + 48'(mu_lo >> 24);
  assign e_bias = mu_neg ? LIM64 - e_mag : LIM64 + e_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid[0] <= 1'b0;
    end else if (en) begin
      x_valid[0] <= mu_valid;
    end
  end

  // side: [9:3] biased integer exponent, [2] zero, [1] overflow, [0] underflow
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= 32'h8000_0000;
      x_f[0]    <= e_bias[31:0];
      x_side[0] <= {e_bias[38:32], mu_zero, !mu_neg && (e_mag >= LIM32),
                    mu_neg && (e_mag > LIM64)};
    end
  end

  // 2^frac cells
  for (genvar i = 0; i < 32; i++) begin : g_exp
    wic_exp2_cell #(.IDX(i + 1), .SW(XSW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (x_valid[i]),
      .in_r     (x_r[i]),
      .in_f     (x_f[i]),
      .in_side  (x_side[i]),
      .out_valid(x_valid[i+1]),
      .out_r    (x_r[i+1]),
      .out_f    (x_f[i+1]),
      .out_side (x_side[i+1])
    );
  end

  // scale times mantissa
  logic           p_valid;
  logic [63:0]    p_val;
  logic [XSW-1:0] p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= x_valid[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_val  <= 64'(scale) * 64'(x_r[32]);
      p_side <= x_side[32];
    end
  end

  // shift by the integer exponent and saturate
  logic [6:0]  p_kb;
  logic [6:0]  sh;
  logic [63:0] res;
  logic [31:0] out_val;
  logic        out_sat;

  assign p_kb = p_side[9:3];
  assign sh   = 7'd95 - p_kb;

  always_comb begin
    if (p_kb >= 7'd95) begin
      res = p_val;
    end else if (sh >= 7'd64) begin
      res = '0;
    end else begin
      res = p_val >> sh;
    end
    if (p_side[2] || p_side[0]) begin
      out_val = '0;
      out_sat = 1'b0;
    end else if (p_side[1] || (res[63:32] != 32'd0)) begin
      out_val = '1;
      out_sat = 1'b1;
    end else begin
      out_val = res[31:0];
      out_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= out_val;
      m_tuser <= out_sat;
    end
  end

  // a saturated result always carries all ones
  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
    else $error("saturated result without all-ones value");

  // no result comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // the 2^frac mantissa stays in [1,2)
  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    x_valid[32] |-> x_r[32][31])
    else $error("exp2 mantissa below one");

endmodule
